/* hdl/assert_macros.svh */
// Assertion helpers used by the list engine RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Check at every clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check at every clock edge, reset included.
`define ASSERT_RST(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_RST(lbl, clk, prop, msg)
`endif

`endif

/* hdl/alir_pkg.sv */
package alir_pkg;

	localparam int unsigned CAPACITY = 64;
	localparam int unsigned VALUE_W  = 32;
	localparam int unsigned TYPE_W   = 3;
	localparam int unsigned POS_W    = 7;
	localparam int unsigned STAT_W   = 2;
	localparam int unsigned OCNT_W   = 7;

	// Cell index width and registered read tree size
	localparam int unsigned AW     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int unsigned LEAVES = 1 << AW;
	localparam int unsigned CNT_W  = $clog2(CAPACITY + 1);
	localparam int unsigned CMPW   = (CNT_W > POS_W) ? CNT_W : POS_W;
	localparam int unsigned WAIT_W = (AW > 1) ? $clog2(AW) : 1;

	localparam logic [CNT_W-1:0]  CAP_CNT   = CNT_W'(CAPACITY);
	localparam logic [WAIT_W-1:0] WAIT_LOAD = WAIT_W'(AW - 1);

	typedef enum logic [TYPE_W-1:0] {
		REQ_INS_FRONT = 3'd0,
		REQ_INS_END   = 3'd1,
		REQ_INS_POS   = 3'd2,
		REQ_RM_FRONT  = 3'd3,
		REQ_RM_END    = 3'd4,
		REQ_RM_POS    = 3'd5,
		REQ_READ      = 3'd6
	} req_type_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		OP_NONE = 2'd0,
		OP_INS  = 2'd1,
		OP_REM  = 2'd2,
		OP_READ = 2'd3
	} op_t;

	// Shift command broadcast to every cell
	typedef struct packed {
		logic               ins;
		logic               rem;
		logic [AW-1:0]      at;
		logic [VALUE_W-1:0] tag;
	} cell_ctl_t;

	// Decoded request held while the item is in flight
	typedef struct packed {
		op_t                op;
		status_t            status;
		logic [AW-1:0]      at;
		logic [VALUE_W-1:0] tag;
	} req_t;

	function automatic logic [AW-1:0] cell_idx(input int unsigned i);
		logic [31:0] v;
		v = i;
		return v[AW-1:0];
	endfunction

	function automatic logic [CMPW-1:0] cnt_to_cmp(input logic [CNT_W-1:0] c);
		return CMPW'(c);
	endfunction

	function automatic logic [CMPW-1:0] pos_to_cmp(input logic [POS_W-1:0] p);
		return CMPW'(p);
	endfunction

	function automatic logic [OCNT_W-1:0] cnt_to_out(input logic [CNT_W-1:0] c);
		logic [CMPW-1:0] t;
		t = CMPW'(c);
		return t[OCNT_W-1:0];
	endfunction

endpackage

/* hdl/alir_ifs.sv */
interface alir_req_if;
	logic                          valid;
	logic                          ready;
	logic [alir_pkg::TYPE_W-1:0]   req_type;
	logic [alir_pkg::POS_W-1:0]    position;
	logic [alir_pkg::VALUE_W-1:0]  entry_value;

	modport source (output valid, req_type, position, entry_value, input ready);
	modport sink   (input valid, req_type, position, entry_value, output ready);
endinterface

interface alir_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [alir_pkg::STAT_W-1:0]   status;
	logic [alir_pkg::VALUE_W-1:0]  out_value;
	logic [alir_pkg::OCNT_W-1:0]   out_count;

	modport source (output valid, status, out_value, out_count, input ready);
	modport sink   (input valid, status, out_value, out_count, output ready);
endinterface

/* hdl/array_list_insert_remove_unit.sv */
// Ordered list engine over a row of entry cells.
// req channel (sink): one item per request with req_type, position and entry_value.
// rsp channel (source): exactly one item per request with status, out_value and
// out_count, in request order.
// The list lives in CAPACITY cells; cell i holds entry i. A committed insert or
// remove shifts the cells at and above the selected slot by one place.
// Reads and removes fetch the selected entry through a registered OR tree of
// $clog2(CAPACITY) levels (6 at the default capacity).
// Inserts, failed requests and the unused type go from acceptance straight to
// the finish state; removes and reads first wait in S_WAIT while the selected
// entry climbs the read tree. One request is in flight at a time and the next
// is taken the cycle after the result commits, so the engine takes no new
// request before it is through with the last one.
// A finished rsp item sits in an output register; the engine takes the next
// request while it waits, and a stalled receiver only holds the engine when
// the next result is ready to commit.
// Reset clears the entry count, the state, the wait counter and the output valid;
// cell contents are left as is and are never returned before being written.
`include "assert_macros.svh"

module array_list_insert_remove_unit (
	input  logic      clk,
	input  logic      arst_n,
	alir_req_if.sink  req,
	alir_rsp_if.source rsp
);

	typedef enum logic [2:0] {
		S_IDLE   = 3'b001,
		S_WAIT   = 3'b010,
		S_FINISH = 3'b100
	} state_t;

	state_t                           state_q;
	logic [alir_pkg::CNT_W-1:0]       count_q;
	logic [alir_pkg::WAIT_W-1:0]      wait_q;
	alir_pkg::req_t                   req_s1;
	alir_pkg::req_t                   dec;
	alir_pkg::cell_ctl_t              ctl;
	logic                             rsp_valid_q;
	alir_pkg::status_t                rsp_status_q;
	logic [alir_pkg::VALUE_W-1:0]     rsp_value_q;
	logic [alir_pkg::OCNT_W-1:0]      rsp_count_q;
	logic                             slot_free;
	logic                             commit;
	logic [alir_pkg::CNT_W-1:0]       count_nxt;
	logic [alir_pkg::CMPW-1:0]        pos_x;
	logic [alir_pkg::CMPW-1:0]        cnt_x;
	logic [alir_pkg::CMPW-1:0]        last_x;
	logic [alir_pkg::VALUE_W-1:0]     cell_val [alir_pkg::CAPACITY];
	logic [alir_pkg::VALUE_W-1:0]     leaf [alir_pkg::LEAVES];
	logic [alir_pkg::VALUE_W-1:0]     root;

	assign pos_x  = alir_pkg::pos_to_cmp(req.position);
	assign cnt_x  = alir_pkg::cnt_to_cmp(count_q);
	assign last_x = cnt_x - 1'b1;

	// Decode the incoming item against the current count
	always_comb begin
		dec.op     = alir_pkg::OP_NONE;
		dec.status = alir_pkg::ST_OK;
		dec.at     = '0;
		dec.tag    = req.entry_value;
		unique case (req.req_type)
			alir_pkg::REQ_INS_FRONT, alir_pkg::REQ_INS_END, alir_pkg::REQ_INS_POS: begin
				priority if (count_q == alir_pkg::CAP_CNT) begin
					dec.status = alir_pkg::ST_FULL;
				end else if (req.req_type == alir_pkg::REQ_INS_POS && pos_x > cnt_x) begin
					dec.status = alir_pkg::ST_RANGE;
				end else begin
					dec.op = alir_pkg::OP_INS;
					unique case (req.req_type)
						alir_pkg::REQ_INS_FRONT: dec.at = '0;
						alir_pkg::REQ_INS_END:   dec.at = cnt_x[alir_pkg::AW-1:0];
						default:                 dec.at = pos_x[alir_pkg::AW-1:0];
					endcase
				end
			end
			alir_pkg::REQ_RM_FRONT, alir_pkg::REQ_RM_END, alir_pkg::REQ_RM_POS,
			alir_pkg::REQ_READ: begin
				priority if (count_q == '0) begin
					dec.status = alir_pkg::ST_EMPTY;
				end else if ((req.req_type == alir_pkg::REQ_RM_POS ||
						req.req_type == alir_pkg::REQ_READ) && pos_x >= cnt_x) begin
					dec.status = alir_pkg::ST_RANGE;
				end else begin
					dec.op = (req.req_type == alir_pkg::REQ_READ) ? alir_pkg::OP_READ
						: alir_pkg::OP_REM;
					unique case (req.req_type)
						alir_pkg::REQ_RM_FRONT: dec.at = '0;
						alir_pkg::REQ_RM_END:   dec.at = last_x[alir_pkg::AW-1:0];
						default:                dec.at = pos_x[alir_pkg::AW-1:0];
					endcase
				end
			end
			default: begin
				dec.op = alir_pkg::OP_NONE;
			end
		endcase
	end

	assign req.ready = (state_q == S_IDLE);
	assign slot_free = !rsp_valid_q || rsp.ready;
	assign commit    = (state_q == S_FINISH) && slot_free;

	// Broadcast the shift command; only a committing insert or remove moves cells
	assign ctl.ins = commit && (req_s1.op == alir_pkg::OP_INS);
	assign ctl.rem = commit && (req_s1.op == alir_pkg::OP_REM);
	assign ctl.at  = req_s1.at;
	assign ctl.tag = req_s1.tag;

	always_comb begin
		unique case (req_s1.op)
			alir_pkg::OP_INS: count_nxt = count_q + 1'b1;
			alir_pkg::OP_REM: count_nxt = count_q - 1'b1;
			default:          count_nxt = count_q;
		endcase
	end

	// Row of entry cells, each shifting against its neighbors
	for (genvar i = 0; i < alir_pkg::CAPACITY; i++) begin : g_cell
		logic [alir_pkg::VALUE_W-1:0] prev_v;
		logic [alir_pkg::VALUE_W-1:0] next_v;
		if (i == 0) begin : g_first
			assign prev_v = req_s1.tag;
		end else begin : g_prev
			assign prev_v = cell_val[i-1];
		end
		if (i == alir_pkg::CAPACITY - 1) begin : g_last
			assign next_v = '0;
		end else begin : g_next
			assign next_v = cell_val[i+1];
		end
		alir_cell u_cell (
			.clk      (clk),
			.ctl      (ctl),
			.idx      (alir_pkg::cell_idx(i)),
			.prev_val (prev_v),
			.next_val (next_v),
			.val      (cell_val[i]),
			.leaf     (leaf[i])
		);
	end

	// Pad the tree when the capacity is not a power of two
	for (genvar j = alir_pkg::CAPACITY; j < alir_pkg::LEAVES; j++) begin : g_pad
		assign leaf[j] = '0;
	end

	alir_rdtree u_rdtree (
		.clk  (clk),
		.leaf (leaf),
		.root (root)
	);

	// Hold the decoded request for the life of the item
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			req_s1 <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			wait_q  <= '0;
			count_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						wait_q <= alir_pkg::WAIT_LOAD;
						// Removes and reads wait for the selected entry to climb the tree
						state_q <= (dec.op == alir_pkg::OP_REM || dec.op == alir_pkg::OP_READ)
							? S_WAIT : S_FINISH;
					end
				end
				S_WAIT: begin
					if (wait_q == '0) begin
						state_q <= S_FINISH;
					end else begin
						wait_q <= wait_q - 1'b1;
					end
				end
				S_FINISH: begin
					if (slot_free) begin
						state_q <= S_IDLE;
						count_q <= count_nxt;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Output register: load on commit, drop once the receiver takes the item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (commit) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			rsp_status_q <= req_s1.status;
			rsp_value_q  <= (req_s1.op == alir_pkg::OP_REM || req_s1.op == alir_pkg::OP_READ)
				? root : '0;
			rsp_count_q  <= alir_pkg::cnt_to_out(count_nxt);
		end
	end

	assign rsp.valid     = rsp_valid_q;
	assign rsp.status    = rsp_status_q;
	assign rsp.out_value = rsp_value_q;
	assign rsp.out_count = rsp_count_q;

	`ASSERT_RST(a_count_cap, clk, count_q <= alir_pkg::CAP_CNT, "entry count above capacity")
	`ASSERT_CLK(a_ins_count, clk, arst_n, (ctl.ins |=> count_q == $past(count_q) + 1'b1), "insert did not grow count")
	`ASSERT_CLK(a_fail_zero, clk, arst_n, (rsp_valid_q && rsp_status_q != alir_pkg::ST_OK && rsp_value_q != '0) == 1'b0, "failed item carries a value")
	`ASSERT_CLK(a_full_cnt, clk, arst_n, (rsp_valid_q && rsp_status_q == alir_pkg::ST_FULL |-> count_q == alir_pkg::CAP_CNT), "full status below capacity")
	`ASSERT_CLK(a_wait_op, clk, arst_n, (state_q == S_WAIT |-> req_s1.op == alir_pkg::OP_REM || req_s1.op == alir_pkg::OP_READ), "tree wait without a fetch")

endmodule

/* hdl/alir_cell.sv */
module alir_cell (
	input  logic                          clk,
	input  alir_pkg::cell_ctl_t           ctl,
	input  logic [alir_pkg::AW-1:0]       idx,
	input  logic [alir_pkg::VALUE_W-1:0]  prev_val,
	input  logic [alir_pkg::VALUE_W-1:0]  next_val,
	output logic [alir_pkg::VALUE_W-1:0]  val,
	output logic [alir_pkg::VALUE_W-1:0]  leaf
);

	logic [alir_pkg::VALUE_W-1:0] val_q;

	// Insert: cells above the slot take the lower neighbor, the slot takes the tag.
	// Remove: the slot and cells above take the upper neighbor.
	always_ff @(posedge clk) begin
		if (ctl.ins) begin
			if (idx > ctl.at) begin
				val_q <= prev_val;
			end else if (idx == ctl.at) begin
				val_q <= ctl.tag;
			end
		end else if (ctl.rem) begin
			if (idx >= ctl.at) begin
				val_q <= next_val;
			end
		end
	end

	assign val  = val_q;
	assign leaf = (idx == ctl.at) ? val_q : '0;

endmodule

/* hdl/alir_rdtree.sv */
module alir_rdtree (
	input  logic                          clk,
	input  logic [alir_pkg::VALUE_W-1:0]  leaf [alir_pkg::LEAVES],
	output logic [alir_pkg::VALUE_W-1:0]  root
);

	// Heap layout: node k has children 2k and 2k+1; indexes at or above LEAVES are leaves.
	logic [alir_pkg::VALUE_W-1:0] node_q [1:alir_pkg::LEAVES-1];

	for (genvar k = 1; k < alir_pkg::LEAVES; k++) begin : g_node
		if (2 * k >= alir_pkg::LEAVES) begin : g_bottom
			always_ff @(posedge clk) begin
				node_q[k] <= leaf[2*k - alir_pkg::LEAVES] | leaf[2*k + 1 - alir_pkg::LEAVES];
			end
		end else begin : g_inner
			always_ff @(posedge clk) begin
				node_q[k] <= node_q[2*k] | node_q[2*k + 1];
			end
		end
	end

	assign root = node_q[1];

endmodule

/* dv/array_list_insert_remove_unit_tb.sv */
module array_list_insert_remove_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import alir_pkg::*;

	// Request type code that the block decodes to nothing.
	localparam logic [TYPE_W-1:0] REQ_UNUSED = 3'd7;

	localparam int unsigned RANDOM_ITEMS = 700;
	localparam int unsigned SEGMENT_LEN  = 40;
	localparam int unsigned DRAIN_CYCLES = 24;
	// Slowest legal item: an idle gap before the request, the wait through the
	// read tree and a stall at the receiver. About 900 items in all, so this
	// leaves a wide margin.
	localparam int unsigned CYCLE_LIMIT  = 200000;

	// Result of one request as the block should report it.
	typedef struct packed {
		status_t             status;
		logic [VALUE_W-1:0]  value;
		logic [OCNT_W-1:0]   count;
	} list_result_t;

	// Bias of a random segment toward growing, shrinking or holding the list.
	typedef enum int {
		DRIFT_GROW,
		DRIFT_SHRINK,
		DRIFT_HOVER
	} drift_t;

	logic clk;
	logic arst_n;

	alir_req_if req_bus ();
	alir_rsp_if rsp_bus ();

	array_list_insert_remove_unit uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_bus),
		.rsp    (rsp_bus)
	);

	// Shadow of the list contents, front entry at index 0.
	logic [VALUE_W-1:0] list_model[$];
	// Results predicted at request acceptance, oldest first.
	list_result_t       pending_results[$];

	int unsigned fail_count;
	int unsigned requests_sent;
	int unsigned results_checked;
	int unsigned peak_entries;
	int unsigned cycle_count;
	int unsigned status_tally[4];
	// Set to drop all idle cycles on both sides for a stretch.
	bit          no_idle;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Apply one request to the shadow list and return the result it causes.
	// Capacity is checked before the position for inserts; emptiness before
	// the position for removes and reads. The unused type changes nothing.
	function automatic list_result_t apply_request(input logic [TYPE_W-1:0] kind,
			input logic [POS_W-1:0] pos, input logic [VALUE_W-1:0] tag);
		list_result_t r;
		int           size;
		int           at;
		r.status = ST_OK;
		r.value  = '0;
		size     = list_model.size();
		case (kind)
			REQ_INS_FRONT, REQ_INS_END, REQ_INS_POS: begin
				if (size >= CAPACITY) begin
					r.status = ST_FULL;
				end else begin
					at = (kind == REQ_INS_FRONT) ? 0 : (kind == REQ_INS_END) ? size : int'(pos);
					if (at > size)
						r.status = ST_RANGE;
					else
						list_model.insert(at, tag);
				end
			end
			REQ_RM_FRONT, REQ_RM_END, REQ_RM_POS, REQ_READ: begin
				if (size == 0) begin
					r.status = ST_EMPTY;
				end else begin
					at = (kind == REQ_RM_FRONT) ? 0 : (kind == REQ_RM_END) ? size - 1 : int'(pos);
					if (at >= size) begin
						r.status = ST_RANGE;
					end else begin
						r.value = list_model[at];
						if (kind != REQ_READ)
							list_model.delete(at);
					end
				end
			end
			default: ;
		endcase
		r.count = OCNT_W'(list_model.size());
		return r;
	endfunction

	// Mostly random tags, with the all-zero and all-one extremes mixed in.
	function automatic logic [VALUE_W-1:0] pick_tag();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			default: return VALUE_W'($urandom());
		endcase
	endfunction

	// Insert position: usually legal (up to and including the count).
	function automatic logic [POS_W-1:0] pick_insert_pos();
		if ($urandom_range(0, 6) == 0)
			return POS_W'($urandom_range(0, 127));
		return POS_W'($urandom_range(0, list_model.size()));
	endfunction

	// Remove/read position: usually an existing entry.
	function automatic logic [POS_W-1:0] pick_access_pos();
		if (list_model.size() == 0 || $urandom_range(0, 6) == 0)
			return POS_W'($urandom_range(0, 127));
		return POS_W'($urandom_range(0, list_model.size() - 1));
	endfunction

	// Offer one item after a random idle gap, hold it until accepted, then
	// record the result it must produce. Valid is left high for the caller's
	// next item; it drops only when a gap or the end of stimulus follows.
	task automatic send_request(input logic [TYPE_W-1:0] kind, input logic [POS_W-1:0] pos,
			input logic [VALUE_W-1:0] tag);
		int           gap;
		list_result_t r;
		gap = no_idle ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			req_bus.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_bus.valid       <= 1'b1;
		req_bus.req_type    <= kind;
		req_bus.position    <= pos;
		req_bus.entry_value <= tag;
		@(posedge clk);
		while (req_bus.ready !== 1'b1)
			@(posedge clk);
		r = apply_request(kind, pos, tag);
		pending_results.push_back(r);
		status_tally[r.status]++;
		requests_sent++;
		if (list_model.size() > peak_entries)
			peak_entries = list_model.size();
	endtask

	// Compare the result on the bus at this edge with the oldest prediction.
	task automatic check_result();
		list_result_t want;
		if (pending_results.size() == 0) begin
			$error("result with no request outstanding: status %0d value %h count %0d",
				rsp_bus.status, rsp_bus.out_value, rsp_bus.out_count);
			fail_count++;
			return;
		end
		want = pending_results.pop_front();
		results_checked++;
		if (rsp_bus.status !== want.status) begin
			$error("status: expected %0d, actual %0d", want.status, rsp_bus.status);
			fail_count++;
		end
		if (rsp_bus.out_value !== want.value) begin
			$error("out_value: expected %h, actual %h", want.value, rsp_bus.out_value);
			fail_count++;
		end
		if (rsp_bus.out_count !== want.count) begin
			$error("out_count: expected %0d, actual %0d", want.count, rsp_bus.out_count);
			fail_count++;
		end
	endtask

	// Requests against an empty list: every remove and read must report
	// empty, whatever the position, and the unused type must pass through.
	task automatic test_empty_list();
		send_request(REQ_RM_FRONT, 7'd0, '1);
		send_request(REQ_RM_END, 7'd127, '0);
		send_request(REQ_RM_POS, 7'd0, '0);
		send_request(REQ_READ, 7'd0, '0);
		send_request(REQ_READ, 7'd127, '1);
		send_request(REQ_UNUSED, 7'd127, '1);
	endtask

	// Each operation once or more on a short list, with value extremes,
	// append through a position equal to the count, and positions past the end.
	task automatic test_basic_edits();
		send_request(REQ_INS_FRONT, 7'd127, 32'h0000_0000);
		send_request(REQ_INS_END, 7'd0, 32'hFFFF_FFFF);
		send_request(REQ_INS_POS, 7'd1, 32'hA5A5_A5A5);
		send_request(REQ_INS_POS, 7'd4, 32'h1234_5678);
		send_request(REQ_INS_POS, 7'd3, 32'h5A5A_5A5A);
		send_request(REQ_INS_POS, 7'd127, 32'h8000_0001);
		send_request(REQ_INS_POS, 7'd64, 32'h7FFF_FFFE);
		send_request(REQ_READ, 7'd0, '1);
		send_request(REQ_READ, 7'd3, '0);
		send_request(REQ_READ, 7'd4, '0);
		send_request(REQ_RM_POS, 7'd4, '0);
		send_request(REQ_RM_POS, 7'd1, '0);
		send_request(REQ_UNUSED, 7'd0, 32'hDEAD_BEEF);
		send_request(REQ_RM_END, 7'd0, '0);
		send_request(REQ_RM_FRONT, 7'd0, '0);
		send_request(REQ_RM_POS, 7'd0, '0);
		send_request(REQ_READ, 7'd0, '0);
	endtask

	// Fill to capacity with random inserts, hit the full flag on every
	// insert type (a bad position must still read as full), touch the last
	// slot, then drain with random removes and reads.
	task automatic test_full_list();
		logic [TYPE_W-1:0] kind;
		while (list_model.size() < CAPACITY) begin
			kind = TYPE_W'($urandom_range(0, 2));
			send_request(kind, POS_W'($urandom_range(0, list_model.size())), pick_tag());
		end
		send_request(REQ_INS_FRONT, 7'd0, pick_tag());
		send_request(REQ_INS_END, 7'd0, pick_tag());
		send_request(REQ_INS_POS, 7'd0, pick_tag());
		send_request(REQ_INS_POS, 7'd127, pick_tag());
		send_request(REQ_READ, 7'd63, '0);
		send_request(REQ_READ, 7'd64, '0);
		send_request(REQ_RM_POS, 7'd63, '0);
		send_request(REQ_INS_POS, 7'd63, pick_tag());
		send_request(REQ_RM_POS, 7'd64, '0);
		while (list_model.size() > 0) begin
			kind = TYPE_W'($urandom_range(3, 6));
			send_request(kind, POS_W'($urandom_range(0, list_model.size() - 1)), '0);
		end
	endtask

	// Random traffic in segments that drift the list up, down or hold it,
	// so occupancy wanders between empty and full. Some segments run with
	// no idling on either side.
	task automatic test_random_mix();
		int unsigned       counted;
		int unsigned       ins_pct;
		drift_t            drift;
		logic [TYPE_W-1:0] kind;
		logic [POS_W-1:0]  pos;
		counted = 0;
		while (counted < RANDOM_ITEMS) begin
			drift   = drift_t'($urandom_range(0, 2));
			ins_pct = (drift == DRIFT_GROW) ? 72 : (drift == DRIFT_SHRINK) ? 28 : 50;
			no_idle = ($urandom_range(0, 4) == 0);
			repeat (SEGMENT_LEN) begin
				if ($urandom_range(0, 99) < 3)
					kind = REQ_UNUSED;
				else if ($urandom_range(0, 99) < ins_pct)
					kind = TYPE_W'($urandom_range(0, 2));
				else
					kind = TYPE_W'($urandom_range(3, 6));
				if (kind == REQ_INS_POS)
					pos = pick_insert_pos();
				else if (kind == REQ_RM_POS || kind == REQ_READ)
					pos = pick_access_pos();
				else
					pos = POS_W'($urandom_range(0, 127));
				send_request(kind, pos, pick_tag());
				if (kind != REQ_UNUSED)
					counted++;
			end
		end
		no_idle = 1'b0;
	endtask

	// Report coverage, give the verdict and stop.
	task automatic close_run();
		$display("Ran %0d requests, checked %0d results, peak occupancy %0d of %0d entries",
			requests_sent, results_checked, peak_entries, CAPACITY);
		$display("Outcomes: ok %0d, full %0d, empty %0d, out of range %0d",
			status_tally[ST_OK], status_tally[ST_FULL], status_tally[ST_EMPTY],
			status_tally[ST_RANGE]);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	endtask

	// Receiver: stall a random number of cycles before each item, then hold
	// ready until one is taken and check it at the accepting edge.
	initial begin
		int stall;
		rsp_bus.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = no_idle ? 0 : $urandom_range(0, 6);
			if (stall > 0) begin
				rsp_bus.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_bus.ready <= 1'b1;
			@(posedge clk);
			while (rsp_bus.valid !== 1'b1)
				@(posedge clk);
			check_result();
		end
	end

	// Watchdog: end the run as failed if it hangs.
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$error("timeout after %0d cycles, %0d results still outstanding",
			cycle_count, pending_results.size());
		fail_count++;
		close_run();
	end

	// Main sequence: hold reset, run each test in turn, then drain.
	initial begin
		fail_count      = 0;
		requests_sent   = 0;
		results_checked = 0;
		peak_entries    = 0;
		no_idle         = 1'b0;
		foreach (status_tally[i])
			status_tally[i] = 0;
		arst_n              <= 1'b0;
		req_bus.valid       <= 1'b0;
		req_bus.req_type    <= '0;
		req_bus.position    <= '0;
		req_bus.entry_value <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_list();
		test_basic_edits();
		test_full_list();
		test_random_mix();

		req_bus.valid <= 1'b0;
		// Wait for every outstanding result, then let the clock run on through a
		// drain period so that anything unexpected can still show up.
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		close_run();
	end

endmodule

/* files.f */
+incdir+hdl
hdl/alir_pkg.sv
hdl/alir_ifs.sv
hdl/alir_cell.sv
hdl/alir_rdtree.sv
hdl/array_list_insert_remove_unit.sv
dv/array_list_insert_remove_unit_tb.sv
